[rtl/trilinear_voxel_interpolator_core_defines.svh]
// Assertion macros used by the trilinear voxel interpolator core.
`ifndef TRILINEAR_VOXEL_INTERPOLATOR_CORE_DEFINES_SVH
`define TRILINEAR_VOXEL_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TVI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tvi_pkg.sv]
// Types, constants, helper functions and the microcode program of the interpolator.
package tvi_pkg;

    localparam int VOLUME_WORDS = 65536;
    localparam int ADDR_BITS    = 16;
    localparam int VALUE_BITS   = 16;
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int IDX_BITS     = COORD_BITS - FRAC_BITS;
    localparam int DIM_BITS     = 9;
    localparam int W_BITS       = FRAC_BITS + 1;
    localparam int WXY_BITS     = 2 * FRAC_BITS + 1;
    localparam int WEIGHT_BITS  = 3 * FRAC_BITS + 1;
    localparam int ACC_BITS     = 3 * FRAC_BITS + VALUE_BITS;
    localparam int STEP_BITS    = 4;
    localparam int CORNER_BITS  = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [W_BITS-1:0]   ONE_FIX = W_BITS'(1) << FRAC_BITS;
    localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(256);

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_idx_t;

    // Datapath operations selected by the microcode.
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CHECK,
        OP_BASE,
        OP_SXY,
        OP_ISSUE,
        OP_NOP,
        OP_EMIT
    } op_t;

    // Jump conditions of the step counter.
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_WAIT_QUERY,
        JC_IF_OOR,
        JC_HOLD_BUSY
    } jc_t;

    typedef struct packed {
        op_t                    op;
        logic [CORNER_BITS-1:0] corner;
        jc_t                    jc;
        logic [STEP_BITS-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic go;
        logic oor;
        logic busy;
    } cond_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  oor;
    } result_t;

    localparam logic [STEP_BITS-1:0] STEP_WAIT       = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_CHECK      = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_BASE       = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_SXY        = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_FIRST_ISSUE = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_LAST_ISSUE = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_EMIT       = 4'd15;

    // The control store: one word per step.
    function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
        ctrl_t w;
        w = '{op: OP_NOP, corner: '0, jc: JC_NEXT, target: STEP_WAIT};
        priority if (step == STEP_WAIT) begin
            w.op = OP_WAIT;
            w.jc = JC_WAIT_QUERY;
        end else if (step == STEP_CHECK) begin
            w.op     = OP_CHECK;
            w.jc     = JC_IF_OOR;
            w.target = STEP_EMIT;
        end else if (step == STEP_BASE) begin
            w.op = OP_BASE;
        end else if (step == STEP_SXY) begin
            w.op = OP_SXY;
        end else if (step >= STEP_FIRST_ISSUE && step <= STEP_LAST_ISSUE) begin
            w.op     = OP_ISSUE;
            w.corner = step[CORNER_BITS-1:0] - STEP_FIRST_ISSUE[CORNER_BITS-1:0];
        end else if (step == STEP_EMIT) begin
            w.op     = OP_EMIT;
            w.jc     = JC_HOLD_BUSY;
            w.target = STEP_WAIT;
        end else begin
            w.op = OP_NOP;
        end
        return w;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] s);
        return (s > MAX_DIM) ? MAX_DIM : s;
    endfunction

    // Lower neighbor always needed, upper one only for a nonzero fraction.
    function automatic logic axis_ok(input logic [IDX_BITS-1:0]  idx,
                                     input logic [FRAC_BITS-1:0] frac,
                                     input logic [DIM_BITS-1:0]  size);
        logic [DIM_BITS-1:0] lo;
        logic [DIM_BITS-1:0] hi;
        lo = {1'b0, idx};
        hi = lo + DIM_BITS'(1);
        return (lo < size) && ((frac == '0) || (hi < size));
    endfunction

endpackage

[rtl/tvi_channel_if.sv]
// Handshake channel interfaces for the request, result and configuration paths.
interface tvi_in_if
    import tvi_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [ADDR_BITS-1:0]  voxel_address;
    logic [VALUE_BITS-1:0] voxel_value;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COORD_BITS-1:0] coord_z;

    modport source (
        output valid, kind, voxel_address, voxel_value, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, kind, voxel_address, voxel_value, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

interface tvi_out_if
    import tvi_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  out_of_range;

    modport source (output valid, value, out_of_range, input ready);
    modport sink (input valid, value, out_of_range, output ready);
endinterface

interface tvi_cfg_if
    import tvi_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/trilinear_voxel_interpolator_core.sv]
// Top level of the trilinear voxel interpolator: channels, configuration and result register.
//
// Usage: the req channel carries two kinds of request. A load request (kind 0) writes
// voxel_value into the 64K-word volume memory at voxel_address as it is accepted and
// produces no result. A query request (kind 1) carries a point with 8
// fraction bits per axis and produces exactly one result on rsp: the trilinear
// blend of the eight corner voxels, truncated once, or zero with out_of_range set
// when a needed neighbor lies outside size_x, size_y, size_z.
// The cfg channel writes the three size registers (index 0, 1, 2); it is always
// ready, and a write to index 3 is ignored. The user must write sizes only while
// idle; the block does not enforce it. Timing: a 16-step microcode program reads
// the eight corners from the single-port memory one per step and drains the multiply
// pipeline; the result register is loaded on the final step, and the next request is
// taken once the program is back on its waiting step. An out-of-range query jumps
// from the check step straight to the final step. A stalled receiver holds the result
// in the output register; the sequencer parks on its final step until that register
// frees, then returns to accept requests. Reset clears the control state and sets
// every size to 1; voxels stay undefined until loaded.
module trilinear_voxel_interpolator_core
    import tvi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tvi_in_if.sink    req,
    tvi_out_if.source rsp,
    tvi_cfg_if.sink   cfg
);

`include "trilinear_voxel_interpolator_core_defines.svh"

    ctrl_t   ctrl;
    cond_t   cond;
    result_t result;
    logic    oor_now;

    logic req_accept;
    logic load_we;
    logic query_go;
    logic rsp_busy;
    logic emit;

    logic [DIM_BITS-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic                  rsp_valid_reg;
    logic [VALUE_BITS-1:0] rsp_value_reg;
    logic                  rsp_oor_reg;

    // Requests are taken only on the waiting step of the program.
    assign req.ready  = (ctrl.op == OP_WAIT);
    assign req_accept = req.valid && req.ready;
    assign load_we    = req_accept && (req.kind == KIND_LOAD);
    assign query_go   = req_accept && (req.kind == KIND_QUERY);

    // The output register is busy while it holds a result the receiver has not taken.
    assign rsp_busy = rsp_valid_reg && !rsp.ready;
    assign emit     = (ctrl.op == OP_EMIT) && !rsp_busy;

    assign cond.go   = query_go;
    assign cond.oor  = oor_now;
    assign cond.busy = rsp_busy;

    tvi_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    tvi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .load_we      (load_we),
        .query_go     (query_go),
        .load_address (req.voxel_address),
        .load_value   (req.voxel_value),
        .coord_x      (req.coord_x),
        .coord_y      (req.coord_y),
        .coord_z      (req.coord_z),
        .size_x       (size_x_reg),
        .size_y       (size_y_reg),
        .size_z       (size_z_reg),
        .oor_now      (oor_now),
        .result       (result)
    );

    // Configuration writes are accepted on every cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_x_reg <= DIM_BITS'(1);
            size_y_reg <= DIM_BITS'(1);
            size_z_reg <= DIM_BITS'(1);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_SIZE_X: size_x_reg <= cfg.data;
                CFG_SIZE_Y: size_y_reg <= cfg.data;
                CFG_SIZE_Z: size_z_reg <= cfg.data;
                default: begin
                    size_x_reg <= size_x_reg;
                end
            endcase
        end
    end

    // Result register: loaded on the final step, released when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (emit) begin
            rsp_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (emit) begin
            rsp_value_reg <= result.value;
            rsp_oor_reg   <= result.oor;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.value        = rsp_value_reg;
    assign rsp.out_of_range = rsp_oor_reg;

    // A query holds off further requests until its result has been produced.
    `TVI_ASSERT_NEXT(a_query_blocks_req, query_go, !req.ready, "request taken during a query")

    // Producing a result loads the output register and returns to the waiting step.
    `TVI_ASSERT_NEXT(a_emit_completes, emit, rsp_valid_reg && (ctrl.op == OP_WAIT), "result not loaded")

    // An out-of-range result always carries a zero value.
    `TVI_ASSERT_NOW(a_oor_zero, rsp_valid_reg && rsp_oor_reg, rsp_value_reg == '0, "nonzero value on out-of-range result")

endmodule

[rtl/tvi_sequencer.sv]
// Step counter and control store lookup that drive the interpolator datapath.
module tvi_sequencer
    import tvi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cond_t cond,
    output ctrl_t ctrl
);

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;

    assign ctrl = ucode(step_reg);

    always_comb begin
        unique case (ctrl.jc)
            JC_NEXT:       step_next = step_reg + STEP_BITS'(1);
            JC_WAIT_QUERY: step_next = cond.go ? step_reg + STEP_BITS'(1) : step_reg;
            JC_IF_OOR:     step_next = cond.oor ? ctrl.target : step_reg + STEP_BITS'(1);
            JC_HOLD_BUSY:  step_next = cond.busy ? step_reg : ctrl.target;
            default:       step_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/tvi_datapath.sv]
// Volume memory, address unit, range check and the corner weighting pipeline.
module tvi_datapath
    import tvi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 ctrl,
    input  logic                  load_we,
    input  logic                  query_go,
    input  logic [ADDR_BITS-1:0]  load_address,
    input  logic [VALUE_BITS-1:0] load_value,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic [COORD_BITS-1:0] coord_z,
    input  logic [DIM_BITS-1:0]   size_x,
    input  logic [DIM_BITS-1:0]   size_y,
    input  logic [DIM_BITS-1:0]   size_z,
    output logic                  oor_now,
    output result_t               result
);

    logic [VALUE_BITS-1:0] mem [VOLUME_WORDS];

    logic [IDX_BITS-1:0]  ix_reg, iy_reg, iz_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg, fz_reg;
    logic [DIM_BITS-1:0]  sx_c, sy_c, sz_c;

    logic [ADDR_BITS-1:0] t_reg, base_reg, sxy_reg;
    logic                 oor_reg;

    logic [ADDR_BITS-1:0]        am_a, am_c;
    logic [DIM_BITS-1:0]         am_b;
    logic [ADDR_BITS+DIM_BITS-1:0] am_prod;
    logic [ADDR_BITS-1:0]        am_res;

    logic                 ci, cj, ck;
    logic [W_BITS-1:0]    wx, wy, wz;
    logic [2*W_BITS-1:0]  wxy_full;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 zero_w;

    logic                  a_vld_reg, a_k_reg, a_zero_reg;
    logic [WXY_BITS-1:0]   a_wxy_reg;
    logic [VALUE_BITS-1:0] rdata_reg;

    logic                         b_vld_reg;
    logic [WEIGHT_BITS-1:0]       b_w_reg;
    logic [VALUE_BITS-1:0]        b_vox_reg;
    logic [WXY_BITS+W_BITS-1:0]   b_prod;

    logic                              c_vld_reg;
    logic [ACC_BITS-1:0]               c_prod_reg;
    logic [WEIGHT_BITS+VALUE_BITS-1:0] c_prod;

    logic [ACC_BITS-1:0] acc_reg;

    assign sx_c = clamp_dim(size_x);
    assign sy_c = clamp_dim(size_y);
    assign sz_c = clamp_dim(size_z);

    assign oor_now = !(axis_ok(ix_reg, fx_reg, sx_c) && axis_ok(iy_reg, fy_reg, sy_c)
                       && axis_ok(iz_reg, fz_reg, sz_c));

    // Shared multiply-add for the linear address: am_a * am_b + am_c, kept modulo 2^16.
    always_comb begin
        unique case (ctrl.op)
            OP_CHECK: begin
                am_a = {8'b0, iz_reg};
                am_b = sy_c;
                am_c = {8'b0, iy_reg};
            end
            OP_BASE: begin
                am_a = t_reg;
                am_b = sx_c;
                am_c = {8'b0, ix_reg};
            end
            OP_SXY: begin
                am_a = {7'b0, sy_c};
                am_b = sx_c;
                am_c = '0;
            end
            default: begin
                am_a = '0;
                am_b = '0;
                am_c = '0;
            end
        endcase
    end

    assign am_prod = {9'b0, am_a} * {16'b0, am_b};
    assign am_res  = am_prod[ADDR_BITS-1:0] + am_c;

    // Corner bits: bit 0 selects the x neighbor, bit 1 y, bit 2 z.
    assign ci = ctrl.corner[0];
    assign cj = ctrl.corner[1];
    assign ck = ctrl.corner[2];

    assign wx = ci ? {1'b0, fx_reg} : ONE_FIX - {1'b0, fx_reg};
    assign wy = cj ? {1'b0, fy_reg} : ONE_FIX - {1'b0, fy_reg};
    assign wz = a_k_reg ? {1'b0, fz_reg} : ONE_FIX - {1'b0, fz_reg};
    assign wxy_full = {9'b0, wx} * {9'b0, wy};

    assign zero_w = (ci && fx_reg == '0) || (cj && fy_reg == '0) || (ck && fz_reg == '0);

    assign rd_addr = base_reg + {15'b0, ci} + (cj ? {7'b0, sx_c} : '0) + (ck ? sxy_reg : '0);

    assign b_prod = {9'b0, a_wxy_reg} * {17'b0, wz};
    assign c_prod = {16'b0, b_w_reg} * {25'b0, b_vox_reg};

    // Single-port volume memory: loads only while waiting, reads only during issue.
    always_ff @(posedge clk) begin
        if (load_we) begin
            mem[load_address] <= load_value;
        end else if (ctrl.op == OP_ISSUE) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (query_go) begin
            ix_reg <= coord_x[COORD_BITS-1:FRAC_BITS];
            fx_reg <= coord_x[FRAC_BITS-1:0];
            iy_reg <= coord_y[COORD_BITS-1:FRAC_BITS];
            fy_reg <= coord_y[FRAC_BITS-1:0];
            iz_reg <= coord_z[COORD_BITS-1:FRAC_BITS];
            fz_reg <= coord_z[FRAC_BITS-1:0];
        end
        if (ctrl.op == OP_CHECK) begin
            t_reg   <= am_res;
            oor_reg <= oor_now;
        end
        if (ctrl.op == OP_BASE) begin
            base_reg <= am_res;
        end
        if (ctrl.op == OP_SXY) begin
            sxy_reg <= am_res;
        end
        a_k_reg    <= ck;
        a_zero_reg <= zero_w;
        a_wxy_reg  <= wxy_full[WXY_BITS-1:0];
        b_w_reg    <= b_prod[WEIGHT_BITS-1:0];
        // A corner with zero weight was never needed; its data may be anything.
        b_vox_reg  <= a_zero_reg ? '0 : rdata_reg;
        c_prod_reg <= c_prod[ACC_BITS-1:0];
        if (ctrl.op == OP_SXY) begin
            acc_reg <= '0;
        end else if (c_vld_reg) begin
            acc_reg <= acc_reg + c_prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= (ctrl.op == OP_ISSUE);
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    assign result.value = oor_reg ? '0 : acc_reg[ACC_BITS-1:3*FRAC_BITS];
    assign result.oor   = oor_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the trilinear voxel interpolator core.
`timescale 1ns / 100ps

module testbench
    import tvi_pkg::*;
();

    // Cycles the block may still need after the last result before it is idle.
    localparam int SETTLE_CYCLES = 32;
    // Upper bound on the wait for outstanding results during a drain.
    localparam int DRAIN_LIMIT   = 4000;
    // Length of the long receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES   = 400;
    // Number of requests sent under each random volume setting.
    localparam int PHASE_ITEMS   = 100;
    // Number of volume settings visited by the random test.
    localparam int PHASE_COUNT   = 13;
    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

    logic clk;
    logic rst_n;

    tvi_in_if  req_ch ();
    tvi_out_if rsp_ch ();
    tvi_cfg_if cfg_ch ();

    trilinear_voxel_interpolator_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the volume memory and of the three size registers.
    // The loaded flags make sure a query never touches a voxel that was never written.
    logic [VALUE_BITS-1:0] volume_copy  [VOLUME_WORDS];
    bit                    voxel_loaded [VOLUME_WORDS];
    logic [DIM_BITS-1:0]   size_regs    [3];

    // Results predicted for accepted query requests, oldest first.
    result_t expected_samples [$];

    int fail_count  = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int hold_until  = 0;
    bit req_gaps_on = 1'b1;
    bit rsp_gaps_on = 1'b1;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Free-running cycle counter; the receiver hold-off is measured against it.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    // A generous fixed limit on the whole run.
    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    // Effective axis size: anything above the largest dimension is clamped to it.
    function automatic longint unsigned eff_dim(input logic [DIM_BITS-1:0] s);
        return (s > MAX_DIM) ? longint'(MAX_DIM) : longint'(s);
    endfunction

    // The lower neighbor is always needed; the upper one only for a nonzero fraction.
    function automatic bit axis_fits(input longint unsigned idx, input longint unsigned fr,
                                     input longint unsigned dim);
        return (idx < dim) && ((fr == 0) || (idx + 1 < dim));
    endfunction

    function automatic bit in_volume(input logic [COORD_BITS-1:0] cx,
                                     input logic [COORD_BITS-1:0] cy,
                                     input logic [COORD_BITS-1:0] cz);
        return axis_fits(cx[COORD_BITS-1:FRAC_BITS], cx[FRAC_BITS-1:0], eff_dim(size_regs[0]))
            && axis_fits(cy[COORD_BITS-1:FRAC_BITS], cy[FRAC_BITS-1:0], eff_dim(size_regs[1]))
            && axis_fits(cz[COORD_BITS-1:FRAC_BITS], cz[FRAC_BITS-1:0], eff_dim(size_regs[2]));
    endfunction

    // Linear address of voxel (x, y, z); it wraps around the memory size.
    function automatic logic [ADDR_BITS-1:0] voxel_addr(input longint unsigned x,
                                                        input longint unsigned y,
                                                        input longint unsigned z);
        longint unsigned lin;
        lin = (z * eff_dim(size_regs[1]) + y) * eff_dim(size_regs[0]) + x;
        return ADDR_BITS'(lin);
    endfunction

    // Expected result of one query. The blend runs along x, then y, then z at
    // full precision, and the sum is truncated once by 3 * FRAC_BITS.
    function automatic result_t predict_sample(input logic [COORD_BITS-1:0] cx,
                                               input logic [COORD_BITS-1:0] cy,
                                               input logic [COORD_BITS-1:0] cz);
        longint unsigned ix, iy, iz, fx, fy, fz, one, v0, v1, total;
        longint unsigned along_x [2][2];
        longint unsigned along_y [2];
        result_t r;
        r.value = '0;
        r.oor   = 1'b1;
        if (!in_volume(cx, cy, cz))
            return r;
        one = longint'(1) << FRAC_BITS;
        ix = cx[COORD_BITS-1:FRAC_BITS];
        iy = cy[COORD_BITS-1:FRAC_BITS];
        iz = cz[COORD_BITS-1:FRAC_BITS];
        fx = cx[FRAC_BITS-1:0];
        fy = cy[FRAC_BITS-1:0];
        fz = cz[FRAC_BITS-1:0];
        for (int k = 0; k < 2; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                // Upper corners of an axis with zero fraction carry no weight.
                if ((j == 1 && fy == 0) || (k == 1 && fz == 0))
                begin
                    along_x[k][j] = 0;
                end
                else
                begin
                    v0 = volume_copy[voxel_addr(ix, iy + j, iz + k)];
                    v1 = (fx != 0) ? volume_copy[voxel_addr(ix + 1, iy + j, iz + k)] : 0;
                    along_x[k][j] = (one - fx) * v0 + fx * v1;
                end
            end
        end
        for (int k = 0; k < 2; k++)
            along_y[k] = (one - fy) * along_x[k][0] + fy * along_x[k][1];
        total   = (one - fz) * along_y[0] + fz * along_y[1];
        r.value = VALUE_BITS'(total >> (3 * FRAC_BITS));
        r.oor   = 1'b0;
        return r;
    endfunction

    // Voxel values lean toward the two extremes now and then.
    function automatic logic [VALUE_BITS-1:0] rand_voxel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // A coordinate that usually lands inside an axis of the given size.
    function automatic logic [COORD_BITS-1:0] pick_coord(input longint unsigned dim);
        longint unsigned idx;
        logic [FRAC_BITS-1:0] fr;
        idx = (dim == 0) ? 0 : $urandom_range(0, int'(dim) - 1);
        case ($urandom_range(0, 7))
            0, 1:    fr = '0;
            2:       fr = '1;
            3:       fr = FRAC_BITS'(1);
            default: fr = FRAC_BITS'($urandom);
        endcase
        // On the last index a nonzero fraction is out of range; keep that case rarer.
        if (fr != 0 && idx + 1 >= dim && $urandom_range(0, 3) != 0)
            fr = '0;
        return {IDX_BITS'(idx), fr};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Offers one request after a random gap and waits until the block takes it.
    // The shadow state is updated at the accepting edge, so each query is
    // predicted against exactly the loads that went before it.
    task automatic send_request(input kind_t kind,
                                input logic [ADDR_BITS-1:0]  addr,
                                input logic [VALUE_BITS-1:0] val,
                                input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [COORD_BITS-1:0] cz);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.voxel_address <= addr;
        req_ch.voxel_value   <= val;
        req_ch.coord_x       <= cx;
        req_ch.coord_y       <= cy;
        req_ch.coord_z       <= cz;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (kind == KIND_LOAD)
        begin
            volume_copy[addr]  = val;
            voxel_loaded[addr] = 1'b1;
        end
        else
        begin
            expected_samples.push_back(predict_sample(cx, cy, cz));
        end
        items_sent++;
    endtask

    // The coordinate fields of a load request carry random noise.
    task automatic load_voxel(input logic [ADDR_BITS-1:0] addr,
                              input logic [VALUE_BITS-1:0] val);
        send_request(KIND_LOAD, addr, val, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom));
    endtask

    // Sends a query; for a point inside the volume, any of its eight corners
    // that was never loaded is loaded first with a random voxel.
    task automatic query_point(input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic [COORD_BITS-1:0] cz);
        logic [ADDR_BITS-1:0] a;
        if (in_volume(cx, cy, cz))
        begin
            for (int k = 0; k < 2; k++)
                for (int j = 0; j < 2; j++)
                    for (int i = 0; i < 2; i++)
                    begin
                        a = voxel_addr(cx[COORD_BITS-1:FRAC_BITS] + i,
                                       cy[COORD_BITS-1:FRAC_BITS] + j,
                                       cz[COORD_BITS-1:FRAC_BITS] + k);
                        if (!voxel_loaded[a])
                            load_voxel(a, rand_voxel());
                    end
        end
        send_request(KIND_QUERY, ADDR_BITS'($urandom), VALUE_BITS'($urandom), cx, cy, cz);
    endtask

    // Stops offering requests and waits until every predicted result has come
    // back. Loads produce no result, so a few more cycles pass before the block
    // counts as idle.
    task automatic wait_idle();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_samples.size() != 0)
        begin
            report_mismatch("results never returned", 0, expected_samples.size());
            expected_samples.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [DIM_BITS-1:0] setting);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= setting;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_SIZE_X: size_regs[0] = setting;
            CFG_SIZE_Y: size_regs[1] = setting;
            CFG_SIZE_Z: size_regs[2] = setting;
            default:    ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_volume(input logic [DIM_BITS-1:0] sx, input logic [DIM_BITS-1:0] sy,
                              input logic [DIM_BITS-1:0] sz);
        wait_idle();
        write_register(CFG_SIZE_X, sx);
        write_register(CFG_SIZE_Y, sy);
        write_register(CFG_SIZE_Z, sz);
    endtask

    // Sizes straight out of reset are 1 x 1 x 1: only the point at the origin
    // with zero fractions is inside; any nonzero fraction or index is outside.
    task automatic test_reset_sizes();
        load_voxel('0, '1);
        query_point(16'h0000, 16'h0000, 16'h0000);
        query_point(16'h0001, 16'h0000, 16'h0000);
        query_point(16'h0000, 16'h0000, 16'h0080);
        query_point(16'h0100, 16'h0000, 16'h0000);
    endtask

    // A 2 x 2 x 2 volume in a checkerboard of the extreme voxel values, queried
    // at both corners, the center, the largest fraction, a zero fraction on one
    // axis only, and one step past the upper edge.
    task automatic test_blend_extremes();
        logic [ADDR_BITS-1:0] a;
        set_volume(9'd2, 9'd2, 9'd2);
        for (int n = 0; n < 8; n++)
        begin
            a = ADDR_BITS'(n);
            load_voxel(a, (a[0] ^ a[1] ^ a[2]) ? '1 : '0);
        end
        query_point(16'h0000, 16'h0000, 16'h0000);
        query_point(16'h0100, 16'h0100, 16'h0100);
        query_point(16'h0080, 16'h0080, 16'h0080);
        query_point(16'h00FF, 16'h00FF, 16'h00FF);
        query_point(16'h0080, 16'h0000, 16'h0080);
        query_point(16'h01FF, 16'h0000, 16'h0000);
    endtask

    // A size of zero puts every point outside; oversized sizes clamp to the
    // largest dimension; a write to the unused register index changes nothing.
    task automatic test_size_limits();
        set_volume(9'd0, 9'd0, 9'd0);
        query_point(16'h0000, 16'h0000, 16'h0000);
        set_volume(9'h1FF, 9'd1, 9'd257);
        query_point(16'hFF00, 16'h0000, 16'hFF00);
        query_point(16'hFF01, 16'h0000, 16'h0000);
        wait_idle();
        write_register(CFG_UNUSED_IDX, 9'h1FF);
        query_point(16'hFF00, 16'h0000, 16'h0000);
        query_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // With a 256 x 256 x 2 volume the second slice starts past the end of
    // memory, so its addresses wrap back onto the first slice.
    task automatic test_address_wrap();
        set_volume(9'd256, 9'd256, 9'd2);
        load_voxel('0, rand_voxel());
        query_point(16'h0000, 16'h0000, 16'h0100);
    endtask

    // Random traffic under a series of volume settings: fixed extremes first,
    // then random small volumes with an occasional wide or zero axis. Most
    // requests are well-formed queries with their corners loaded first; the
    // rest are stray loads and queries at arbitrary points. Some phases run
    // without gaps on one side to give unbroken stretches.
    task automatic test_random_phases();
        logic [DIM_BITS-1:0]   dims [3];
        logic [COORD_BITS-1:0] c [3];
        int start_count;
        int roll;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       dims = '{9'd1, 9'd1, 9'd1};
                1:       dims = '{9'd256, 9'd1, 9'd1};
                2:       dims = '{9'd1, 9'd256, 9'd1};
                3:       dims = '{9'd1, 9'd1, 9'd256};
                4:       dims = '{9'd256, 9'd256, 9'd256};
                5:       dims = '{9'd0, 9'd4, 9'd4};
                6:       dims = '{9'd3, 9'd5, 9'd7};
                default:
                begin
                    for (int d = 0; d < 3; d++)
                        dims[d] = ($urandom_range(0, 5) == 0) ? DIM_BITS'($urandom_range(0, 511))
                                                              : DIM_BITS'($urandom_range(1, 8));
                end
            endcase
            set_volume(dims[0], dims[1], dims[2]);
            req_gaps_on = (p % 4 != 1);
            rsp_gaps_on = (p % 4 != 2);
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                begin
                    load_voxel(ADDR_BITS'($urandom), rand_voxel());
                end
                else if (roll < 30)
                begin
                    query_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                COORD_BITS'($urandom));
                end
                else
                begin
                    for (int d = 0; d < 3; d++)
                        c[d] = pick_coord(eff_dim(size_regs[d]));
                    query_point(c[0], c[1], c[2]);
                end
            end
        end
        req_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while queries keep coming
    // back to back, so the result register fills and the request side stalls.
    task automatic test_backpressure();
        set_volume(9'd4, 9'd4, 9'd4);
        req_gaps_on = 1'b0;
        hold_until <= cycle_count + HOLD_CYCLES;
        repeat (16)
            query_point(pick_coord(4), pick_coord(4), pick_coord(4));
        wait_idle();
        req_gaps_on = 1'b1;
    endtask

    // Result side: draws a stall for every result, honors the long hold-off,
    // and checks each accepted result field by field against the oldest
    // prediction.
    initial
    begin : result_checker
        result_t want;
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rsp_gaps_on ? $urandom_range(0, 5) : 0;
            if (stall > 0 || cycle_count < hold_until)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (cycle_count < hold_until) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            if (expected_samples.size() == 0)
            begin
                report_mismatch("result with no query pending", rsp_ch.value, 0);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (rsp_ch.value !== want.value)
                    report_mismatch("value", rsp_ch.value, want.value);
                if (rsp_ch.out_of_range !== want.oor)
                    report_mismatch("out_of_range", rsp_ch.out_of_range, want.oor);
            end
        end
    end

    // Request and configuration side: reset, then the tests in turn.
    initial
    begin : stimulus
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= KIND_LOAD;
        req_ch.voxel_address <= '0;
        req_ch.voxel_value   <= '0;
        req_ch.coord_x       <= '0;
        req_ch.coord_y       <= '0;
        req_ch.coord_z       <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_SIZE_X;
        cfg_ch.data          <= '0;
        rst_n                <= 1'b0;
        // Every size register comes out of reset at 1.
        for (int d = 0; d < 3; d++)
            size_regs[d] = DIM_BITS'(1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_blend_extremes();
        test_size_limits();
        test_address_wrap();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tvi_pkg.sv
rtl/tvi_channel_if.sv
rtl/tvi_sequencer.sv
rtl/tvi_datapath.sv
rtl/trilinear_voxel_interpolator_core.sv
tb/testbench.sv
